FILE: sv/cpwm_pkg.sv
// Shared types, constants and compare arithmetic for the complementary PWM generator.
package cpwm_pkg;

  localparam int COUNT_W  = 16;  // timer count and compare width
  localparam int FRAC_W   = 16;  // Q1.15 duty field width
  localparam int FRAC_BITS = 15; // fractional bits of the duty
  localparam int DEAD_W   = 7;   // dead-time counter width
  localparam int STEP_W   = 17;  // signed compare step width
  localparam int PROD_W   = COUNT_W + FRAC_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int MODE_W     = 3;

  localparam logic [COUNT_W-1:0] TOP_RST     = 16'd24000;
  localparam logic [DEAD_W-1:0]  DEAD_RST    = 7'd0;
  localparam logic [FRAC_W-1:0]  MIN_RST     = 16'd0;
  localparam logic [FRAC_W-1:0]  MAX_RST     = 16'd32768;
  localparam logic [COUNT_W-1:0] COMPARE_RST = 16'd12000;

  // cycles needed to rebuild the limit products after a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 3'd0,
    MODE_DUTY  = 3'd1,
    MODE_STEP  = 3'd2,
    MODE_START = 3'd3,
    MODE_STOP  = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_TOP  = 4'd0,
    CFG_DEAD_CLOCKS = 4'd1,
    CFG_MIN_DUTY    = 4'd2,
    CFG_MAX_DUTY    = 4'd3
  } cfg_idx_t;

  // configuration and derived limits seen by the datapath
  typedef struct packed {
    logic [COUNT_W-1:0] top;
    logic [DEAD_W-1:0]  dead;
    logic [FRAC_W-1:0]  duty_floor;
    logic [FRAC_W-1:0]  duty_ceil;
    logic [PROD_W-1:0]  prod_min;   // duty floor * top
    logic [PROD_W-1:0]  prod_max;   // duty ceiling * top
    logic [COUNT_W-1:0] cmp_min;    // compare for set duty at the duty floor
    logic [COUNT_W-1:0] cmp_max;    // compare for set duty at the duty ceiling
    logic               settled;
  } cpwm_cfg_t;

  // scale a duty product to a compare count, saturated to top
  function automatic logic [COUNT_W-1:0] sat_compare(input logic [PROD_W-1:0] prod,
                                                     input logic [COUNT_W-1:0] top);
    logic [PROD_W-FRAC_BITS-1:0] q;
    q = prod[PROD_W-1:FRAC_BITS];
    if (q > (PROD_W-FRAC_BITS)'(top)) return top;
    return q[COUNT_W-1:0];
  endfunction

endpackage

FILE: sv/cpwm_cfg.sv
// Configuration registers and precomputed duty-limit products.
module cpwm_cfg import cpwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cpwm_cfg_t             cfg
);

  logic [COUNT_W-1:0] top_r;
  logic [DEAD_W-1:0]  dead_r;
  logic [FRAC_W-1:0]  min_r, max_r;
  logic [PROD_W-1:0]  prod_min_r, prod_max_r;
  logic [COUNT_W-1:0] cmp_min_r, cmp_max_r;
  logic [1:0]         settle_r, settle_nxt;
  logic [PROD_W-1:0]  prod_lo, prod_hi;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= TOP_RST;
      dead_r <= DEAD_RST;
      min_r  <= MIN_RST;
      max_r  <= MAX_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_PERIOD_TOP:  top_r  <= wr_data[COUNT_W-1:0];
        CFG_DEAD_CLOCKS: dead_r <= wr_data[DEAD_W-1:0];
        CFG_MIN_DUTY:    min_r  <= wr_data[FRAC_W-1:0];
        CFG_MAX_DUTY:    max_r  <= wr_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // duty clamp of a limit itself: a min above max ends up at max, and the reverse
  always_comb begin
    prod_lo = (min_r > max_r) ? prod_max_r : prod_min_r;
    prod_hi = (max_r < min_r) ? prod_min_r : prod_max_r;
  end

  // stage 1: limit products, stage 2: limit compares
  always_ff @(posedge clk) begin
    prod_min_r <= top_r * min_r;
    prod_max_r <= top_r * max_r;
    cmp_min_r  <= sat_compare(prod_lo, top_r);
    cmp_max_r  <= sat_compare(prod_hi, top_r);
  end

  // hold off items until both stages reflect the current registers
  always_comb begin
    settle_nxt = settle_r;
    if (wr_en) settle_nxt = SETTLE_CYCLES;
    else if (settle_r != 2'd0) settle_nxt = settle_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) settle_r <= SETTLE_CYCLES;
    else        settle_r <= settle_nxt;
  end

  always_comb begin
    cfg.top        = top_r;
    cfg.dead       = dead_r;
    cfg.duty_floor = min_r;
    cfg.duty_ceil  = max_r;
    cfg.prod_min   = prod_min_r;
    cfg.prod_max   = prod_max_r;
    cfg.cmp_min    = cmp_min_r;
    cfg.cmp_max    = cmp_max_r;
    cfg.settled    = (settle_r == 2'd0);
  end

endmodule

FILE: sv/cpwm_core.sv
// Timer state, compare update and dead-time gate logic, one item per cycle while fire is high.
module cpwm_core import cpwm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cpwm_cfg_t           cfg,
  input  logic                fire,
  input  mode_t               mode,
  input  logic [FRAC_W-1:0]   duty_fraction,
  input  logic [STEP_W-1:0]   step_delta,
  output logic                high_gate,
  output logic                low_gate,
  output logic [COUNT_W-1:0]  counter_value,
  output logic                counting_down,
  output logic [COUNT_W-1:0]  compare_readback,
  output logic                outputs_enabled
);

  localparam int T_W = COUNT_W + 2;           // shadow plus signed step
  localparam int S_W = T_W + FRAC_BITS + 1;   // scaled step with headroom

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               down_r, down_nxt;
  logic [COUNT_W-1:0] shadow_r, shadow_nxt;
  logic [COUNT_W-1:0] active_r, active_nxt;
  logic               ref_prev_r, ref_prev_nxt;
  logic [DEAD_W-1:0]  dead_r, dead_nxt;
  logic               high_r, high_nxt;
  logic               low_r, low_nxt;
  logic               drive_r, drive_nxt;

  logic [COUNT_W-1:0] t_count, t_active;
  logic               t_down, t_ref;
  logic [FRAC_W-1:0]  target;
  logic [PROD_W-1:0]  duty_prod;
  logic [COUNT_W-1:0] duty_cmp, step_cmp;
  logic signed [T_W-1:0] step_sum;
  logic signed [S_W-1:0] scaled;

  // counter advance with turnaround and compare reload
  always_comb begin
    t_count  = count_r;
    t_down   = down_r;
    t_active = active_r;
    if (!down_r) begin
      if (count_r >= cfg.top) begin
        t_down   = 1'b1;
        t_count  = (cfg.top != '0) ? cfg.top - 1'b1 : '0;
        t_active = shadow_r;
      end else begin
        t_count = count_r + 1'b1;
      end
    end else begin
      if (count_r == '0) begin
        t_down   = 1'b0;
        t_count  = (cfg.top != '0) ? COUNT_W'(1) : '0;
        t_active = shadow_r;
      end else begin
        t_count = count_r - 1'b1;
      end
    end
    t_ref = t_count < t_active;
  end

  // set duty: clamp, scale by top, saturate
  always_comb begin
    if (duty_fraction < cfg.duty_floor)     target = cfg.duty_floor;
    else if (duty_fraction > cfg.duty_ceil) target = cfg.duty_ceil;
    else                                    target = duty_fraction;
    duty_prod = cfg.top * target;
    duty_cmp  = sat_compare(duty_prod, cfg.top);
  end

  // step: limit test against precomputed products, then clamp to 0..top
  always_comb begin
    step_sum = $signed({2'b00, shadow_r}) + $signed({step_delta[STEP_W-1], step_delta});
    scaled   = $signed({step_sum[T_W-1], step_sum, {FRAC_BITS{1'b0}}});
    if (scaled < $signed((S_W)'(cfg.prod_min)))      step_cmp = cfg.cmp_min;
    else if (scaled > $signed((S_W)'(cfg.prod_max))) step_cmp = cfg.cmp_max;
    else if (step_sum < 0)                           step_cmp = '0;
    else if (step_sum > $signed({2'b00, cfg.top}))   step_cmp = cfg.top;
    else                                             step_cmp = step_sum[COUNT_W-1:0];
  end

  // next state for the item in hand
  always_comb begin
    count_nxt    = count_r;
    down_nxt     = down_r;
    shadow_nxt   = shadow_r;
    active_nxt   = active_r;
    ref_prev_nxt = ref_prev_r;
    dead_nxt     = dead_r;
    high_nxt     = high_r;
    low_nxt      = low_r;
    drive_nxt    = drive_r;
    if (fire) begin
      unique case (mode)
        MODE_TICK: begin
          count_nxt    = t_count;
          down_nxt     = t_down;
          active_nxt   = t_active;
          ref_prev_nxt = t_ref;
          if (t_ref != ref_prev_r) begin
            // reference edge: both gates off and dead time starts; with zero dead time the gates follow at once
            high_nxt = 1'b0;
            low_nxt  = 1'b0;
            dead_nxt = cfg.dead;
            if (cfg.dead == '0) begin
              high_nxt = t_ref;
              low_nxt  = !t_ref;
            end
          end else if (dead_r != '0) begin
            dead_nxt = dead_r - 1'b1;
            if (dead_r == DEAD_W'(1)) begin
              high_nxt = t_ref;
              low_nxt  = !t_ref;
            end
          end else begin
            high_nxt = t_ref;
            low_nxt  = !t_ref;
          end
        end
        MODE_DUTY:  shadow_nxt = duty_cmp;
        MODE_STEP:  shadow_nxt = step_cmp;
        MODE_START: drive_nxt  = 1'b1;
        MODE_STOP:  drive_nxt  = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      down_r     <= 1'b0;
      shadow_r   <= COMPARE_RST;
      active_r   <= COMPARE_RST;
      ref_prev_r <= 1'b0;
      dead_r     <= '0;
      high_r     <= 1'b0;
      low_r      <= 1'b0;
      drive_r    <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      down_r     <= down_nxt;
      shadow_r   <= shadow_nxt;
      active_r   <= active_nxt;
      ref_prev_r <= ref_prev_nxt;
      dead_r     <= dead_nxt;
      high_r     <= high_nxt;
      low_r      <= low_nxt;
      drive_r    <= drive_nxt;
    end
  end

  // result reflects state after the item
  always_comb begin
    high_gate        = drive_nxt & high_nxt;
    low_gate         = drive_nxt & low_nxt;
    counter_value    = count_nxt;
    counting_down    = down_nxt;
    compare_readback = shadow_nxt;
    outputs_enabled  = drive_nxt;
  end

endmodule

FILE: sv/complementary_pwm_deadtime_generator_top.sv
// Top level of the center-aligned complementary PWM generator with dead time.
// Takes one item per clock unless the result sink stalls or the configuration is
// settling, and returns one result item per input item. An accepted item waits in
// the input register; the combinational datapath then loads the result register as
// soon as that register can take the item, and out_tvalid rises with that load. The
// longest path is the set-duty 16x16 multiply with its clamp and saturation.
// After reset and after every configuration write, in_tready stays low while
// the duty-limit products and compares are rebuilt.
// Configuration writes are always taken (cfg_ready is high).
module complementary_pwm_deadtime_generator_top import cpwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] duty_fraction, [32:16] step_delta
  input  logic [MODE_W-1:0]     in_tuser,   // [2:0] mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] high_gate, [1] low_gate, [17:2] counter_value, [18] counting_down,
  // [34:19] compare_readback, [35] outputs_enabled
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cpwm_cfg_t           cfg;
  logic                in_valid_r, in_valid_nxt;
  logic [MODE_W-1:0]   mode_r;
  logic [FRAC_W-1:0]   duty_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                advance, fire, in_accept;

  logic               r_high, r_low, r_down, r_en;
  logic [COUNT_W-1:0] r_count, r_cmp;

  assign cfg_ready = 1'b1;

  cpwm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // handshake: when settled, input register refills once the result register is free
  always_comb begin
    advance   = !out_valid_r || out_tready;
    fire      = in_valid_r && advance;
    in_tready = cfg.settled && (!in_valid_r || advance);
    in_accept = in_tvalid && in_tready;
    in_valid_nxt  = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_r);
    out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r <= in_tuser;
      duty_r <= in_tdata[FRAC_W-1:0];
      step_r <= in_tdata[FRAC_W+STEP_W-1:FRAC_W];
    end
  end

  cpwm_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .fire             (fire),
    .mode             (mode_t'(mode_r)),
    .duty_fraction    (duty_r),
    .step_delta       (step_r),
    .high_gate        (r_high),
    .low_gate         (r_low),
    .counter_value    (r_count),
    .counting_down    (r_down),
    .compare_readback (r_cmp),
    .outputs_enabled  (r_en)
  );

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {4'b0000, r_en, r_cmp, r_down, r_count, r_low, r_high};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sv/cpwm_checker.sv
// Port-level checks for the complementary PWM generator, bound to the top level.
module cpwm_checker import cpwm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // gates are never both on
  a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("both gates on");

  // a gate is on only while outputs are enabled
  a_gate_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[0] || out_tdata[1]) |-> out_tdata[35])
    else $error("gate on while outputs stopped");

  // an accepted item taken while the sink is ready must be followed by a valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tready |=> ##1 out_tvalid)
    else $error("result missing after accepted item");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind complementary_pwm_deadtime_generator_top cpwm_checker u_cpwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
